FILE: rtl/sorted_table_engine_assert.svh
// Assertion macros used by the sequencer of the sorted table engine.
`ifndef SORTED_TABLE_ENGINE_ASSERT_SVH
`define SORTED_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ste_pkg.sv
// Types and constants of the sorted table engine.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

   localparam int DEPTH       = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Request kinds
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_FIND   = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_GET    = 2'd3;

   // Response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [DATA_WIDTH-1:0] value;
      logic [ADDR_WIDTH-1:0] index;
   } ste_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [ADDR_WIDTH-1:0]  position;
      logic [DATA_WIDTH-1:0]  read_value;
      logic [COUNT_WIDTH-1:0] count;
   } ste_rsp_type;

   // Store access issued by the sequencer
   typedef struct packed {
      logic                  we;
      logic [ADDR_WIDTH-1:0] waddr;
      logic [DATA_WIDTH-1:0] wdata;
      logic [ADDR_WIDTH-1:0] raddr;
   } ste_mem_cmd_type;

   // Outcome of one probe compare
   typedef struct packed {
      logic hit;
      logic go_up;
   } ste_cmp_type;

endpackage

`default_nettype wire

FILE: rtl/ste_store.sv
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ste_store (
   input  wire                              clock,
   input  ste_pkg::ste_mem_cmd_type         cmd,
   output logic [ste_pkg::DATA_WIDTH-1:0]   rdata
);
   import ste_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   // Read one entry every cycle
   always_ff @(posedge clock) begin
      rdata_ff <= mem[cmd.raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/ste_cmp.sv
// Probe comparator: equality and search direction.
`timescale 1ns / 1ps
`default_nettype none

module ste_cmp (
   input  wire  [ste_pkg::DATA_WIDTH-1:0] entry,
   input  wire  [ste_pkg::DATA_WIDTH-1:0] key,
   input  wire                            ascending,
   output ste_pkg::ste_cmp_type           res
);
   import ste_pkg::*;

   logic lt;

   // Move the lower bound up when the entry sorts before the key
   always_comb begin
      lt        = entry < key;
      res.hit   = entry == key;
      res.go_up = ascending ? lt : (!lt && (entry != key));
   end

endmodule

`default_nettype wire

FILE: rtl/ste_ctrl.sv
// Sequencer: bisection, entry shifting and response generation.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_engine_assert.svh"

module ste_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  ste_pkg::ste_req_type             req_item,
   output logic                             busy,
   output logic                             rsp_valid,
   output ste_pkg::ste_rsp_type             rsp_item,
   input  wire  [ste_pkg::DATA_WIDTH-1:0]   rdata,
   input  ste_pkg::ste_cmp_type             cmp,
   output ste_pkg::ste_mem_cmd_type         mem_cmd,
   output logic [ste_pkg::DATA_WIDTH-1:0]   key
);
   import ste_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SEARCH   = 3'd1;
   localparam logic [2:0] ST_PROBE    = 3'd2;
   localparam logic [2:0] ST_UP_RD    = 3'd3;
   localparam logic [2:0] ST_UP_WR    = 3'd4;
   localparam logic [2:0] ST_DN_RD    = 3'd5;
   localparam logic [2:0] ST_DN_WR    = 3'd6;
   localparam logic [2:0] ST_GET_WAIT = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             kind_ff, kind_in;
   logic [DATA_WIDTH-1:0]  key_ff, key_in;
   logic [ADDR_WIDTH-1:0]  idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0] lo_ff, lo_in;
   logic [COUNT_WIDTH-1:0] hi_ff, hi_in;
   logic [COUNT_WIDTH-1:0] ptr_ff, ptr_in;
   logic [ADDR_WIDTH-1:0]  pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ste_rsp_type            rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0] span;
   logic [COUNT_WIDTH-1:0] mid;
   logic [COUNT_WIDTH-1:0] ptr_dec;
   logic [COUNT_WIDTH-1:0] ptr_inc;
   logic [COUNT_WIDTH-1:0] req_idx;

   // Midpoint of the open range and shift pointers
   always_comb begin
      span    = hi_ff - lo_ff - 1'b1;
      mid     = lo_ff + (span >> 1);
      ptr_dec = ptr_ff - 1'b1;
      ptr_inc = ptr_ff + 1'b1;
      req_idx = COUNT_WIDTH'(req_item.index);
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_cmd      = '{we: 1'b0, waddr: '0, wdata: rdata, raddr: '0};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = req_item.req_type;
               key_in  = req_item.value;
               idx_in  = req_item.index;
               lo_in   = '0;
               hi_in   = count_ff;
               case (req_item.req_type)
                  REQ_INSERT: begin
                     if (count_ff == COUNT_WIDTH'(DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: STAT_FULL, position: '0, read_value: '0,
                                   count: count_ff};
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  REQ_FIND: begin
                     state_in = ST_SEARCH;
                  end
                  REQ_REMOVE: begin
                     if (req_idx >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: STAT_RANGE, position: '0, read_value: '0,
                                   count: count_ff};
                     end else begin
                        ptr_in   = req_idx;
                        state_in = ST_DN_RD;
                     end
                  end
                  default: begin
                     if (req_idx >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: STAT_RANGE, position: '0, read_value: '0,
                                   count: count_ff};
                     end else begin
                        mem_cmd.raddr = req_item.index;
                        state_in      = ST_GET_WAIT;
                     end
                  end
               endcase
            end
         end

         // Issue the probe read, or finish an exhausted search
         ST_SEARCH: begin
            if (lo_ff >= hi_ff) begin
               if (kind_ff == REQ_INSERT) begin
                  pos_in   = lo_ff[ADDR_WIDTH-1:0];
                  ptr_in   = count_ff;
                  state_in = ST_UP_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: STAT_NOT_FOUND, position: '0, read_value: '0,
                             count: count_ff};
                  state_in = ST_IDLE;
               end
            end else begin
               mem_cmd.raddr = mid[ADDR_WIDTH-1:0];
               pos_in        = mid[ADDR_WIDTH-1:0];
               state_in      = ST_PROBE;
            end
         end

         // Compare the probed entry and narrow the range
         ST_PROBE: begin
            if (cmp.hit) begin
               if (kind_ff == REQ_INSERT) begin
                  ptr_in   = count_ff;
                  state_in = ST_UP_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: STAT_OK, position: pos_ff, read_value: '0,
                             count: count_ff};
                  state_in = ST_IDLE;
               end
            end else begin
               if (cmp.go_up) begin
                  lo_in = COUNT_WIDTH'(pos_ff) + 1'b1;
               end else begin
                  hi_in = COUNT_WIDTH'(pos_ff);
               end
               state_in = ST_SEARCH;
            end
         end

         // Shift entries up until the gap reaches the insert position
         ST_UP_RD: begin
            if (ptr_ff == COUNT_WIDTH'(pos_ff)) begin
               mem_cmd.we    = 1'b1;
               mem_cmd.waddr = pos_ff;
               mem_cmd.wdata = key_ff;
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_in = '{status: STAT_OK, position: pos_ff, read_value: '0,
                          count: count_in};
               state_in = ST_IDLE;
            end else begin
               mem_cmd.raddr = ptr_dec[ADDR_WIDTH-1:0];
               state_in      = ST_UP_WR;
            end
         end

         ST_UP_WR: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = ptr_ff[ADDR_WIDTH-1:0];
            ptr_in        = ptr_dec;
            state_in      = ST_UP_RD;
         end

         // Shift entries down over the removed one
         ST_DN_RD: begin
            if (ptr_inc >= count_ff) begin
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STAT_OK, position: idx_ff, read_value: '0,
                          count: count_in};
               state_in = ST_IDLE;
            end else begin
               mem_cmd.raddr = ptr_inc[ADDR_WIDTH-1:0];
               state_in      = ST_DN_WR;
            end
         end

         ST_DN_WR: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = ptr_ff[ADDR_WIDTH-1:0];
            ptr_in        = ptr_inc;
            state_in      = ST_DN_RD;
         end

         ST_GET_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{status: STAT_OK, position: idx_ff, read_value: 32'(rdata),
                       count: count_ff};
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload and search registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      ptr_ff  <= ptr_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign key       = key_ff;

   `STE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_WIDTH'(DEPTH), "entry count above depth")
   `STE_ASSERT_IMP(a_rsp_at_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "response while sequencer active")
   `STE_ASSERT_NEXT(a_start_served, clock, reset, (state_ff == ST_IDLE) && start, (state_ff != ST_IDLE) || rsp_valid_ff, "accepted request dropped")
   `STE_ASSERT_IMP(a_count_on_rsp, clock, reset, count_ff != $past(count_ff), rsp_valid_ff, "count changed without a response")

endmodule

`default_nettype wire

FILE: rtl/sorted_table_engine.sv
// Top level of the sorted table engine.
`timescale 1ns / 1ps
`default_nettype none

// Sorted table of 64 unsigned 32-bit entries kept in ascending or descending order (csr_data
// writes the direction; 1 ascending, reset 1; writes are taken while busy is low). A request
// is taken when start is high and busy is low. Its single response appears on rsp_item for
// exactly one cycle with rsp_valid high and cannot be held off, so the receiver must take it
// then. Timing is set by the entry store, which has one write port and one registered read
// port. Every bisection probe is a read, then a compare, and a search makes at most 7
// probes. A search that ends without a hit passes through the search state once more to
// finish. Every entry moved by insert or remove is read, then written, and a final step
// writes the new entry or updates the count and gives the response. Insert is rejected
// when the table is full, remove and get when the index is out of range.
// The store needs no clearing at reset.
module sorted_table_engine (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  ste_pkg::ste_req_type req_item,
   output logic                 rsp_valid,
   output ste_pkg::ste_rsp_type rsp_item,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire                  csr_data
);
   import ste_pkg::*;

   logic                  ascending_ff, ascending_in;
   ste_mem_cmd_type       mem_cmd;
   ste_cmp_type           cmp;
   logic [DATA_WIDTH-1:0] rdata;
   logic [DATA_WIDTH-1:0] key;

   // Accept direction writes between requests
   assign csr_ready = !busy;

   always_comb begin
      ascending_in = ascending_ff;
      if (csr_valid && csr_ready) begin
         ascending_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b1;
      end else begin
         ascending_ff <= ascending_in;
      end
   end

   ste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rdata     (rdata),
      .cmp       (cmp),
      .mem_cmd   (mem_cmd),
      .key       (key)
   );

   ste_store u_store (
      .clock (clock),
      .cmd   (mem_cmd),
      .rdata (rdata)
   );

   ste_cmp u_cmp (
      .entry     (rdata),
      .key       (key),
      .ascending (ascending_ff),
      .res       (cmp)
   );

endmodule

`default_nettype wire
